// ----- design/assert_macros.svh -----
// Concurrent assertion helpers, used by epm_fifo.
// Compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/epm_pkg.sv -----
// Shared constants and types for the exact pattern matcher.
// No dependencies.
package epm_pkg;

    localparam int MAX_PATTERN    = 16;
    localparam int INDEX_BITS     = 16;
    localparam int WINDOW_DEPTH   = 16;
    localparam int WIN_IDX_BITS   = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS       = 5;
    localparam int START_BITS     = 16;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

    typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;
    typedef logic [MAX_PATTERN-1:0][7:0]  pattern_t;

    typedef struct packed {
        window_t               window;
        logic [INDEX_BITS-1:0] pos;
        logic                  last;
    } epm_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } epm_fifo_status_t;

endpackage

// ----- design/exact_pattern_matcher.sv -----
// Top level of the exact pattern matcher: front end, queue, back end.
// Depends on epm_pkg, epm_front, epm_fifo, epm_back.
//
//  channel  dir  handshake          content
//  s_axis   in   tvalid/tready      tdata[7:0] text_byte, tlast text_last
//  m_axis   out  tvalid/tready      tdata[15:0] start_index, tuser found,
//                                   tlast end_of_text
//  cfg      in   cfg_we             cfg_index, cfg_data (64 bit)
//
// One beat per cycle sustained while m_axis accepts.
// Front end and output register are split by a two-entry queue.
// rst_n clears the count, queue and output valid; window contents are don't-care.
// A stalled m_axis fills the queue, then s_tready drops.
module exact_pattern_matcher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // text_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [epm_pkg::START_BITS-1:0]       m_tdata,  // start_index
    output logic                                 m_tuser,  // found
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [epm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [epm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import epm_pkg::*;

    epm_fifo_status_t fifo_status;
    epm_entry_t       push_entry;
    epm_entry_t       head_entry;
    logic             push;
    logic             pop;

    epm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (s_tdata),
        .text_last   (s_tlast),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .fifo_status (fifo_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    epm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (fifo_status)
    );

    epm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_entry  (head_entry),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .found       (m_tuser),
        .start_index (m_tdata),
        .end_of_text (m_tlast)
    );

endmodule

// ----- design/epm_front.sv -----
// Front end: takes text beats, keeps the byte window and position count.
// Depends on epm_pkg.
module epm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                text_byte,
    input  logic                      text_last,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  epm_pkg::epm_fifo_status_t fifo_status,
    output logic                      push,
    output epm_pkg::epm_entry_t       push_entry
);
    import epm_pkg::*;

    window_t               window_reg;
    window_t               window_next;
    logic [INDEX_BITS-1:0] count_reg;
    logic [INDEX_BITS-1:0] count_next;

    assign in_ready    = !fifo_status.full;
    assign push        = in_valid && in_ready;
    assign window_next = {window_reg[WINDOW_DEPTH-2:0], text_byte};

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (text_last)
                count_next = '0;
            else if (count_reg != COUNT_MAX)
                count_next = count_reg + INDEX_BITS'(1);
        end
    end

    assign push_entry.window = window_next;
    assign push_entry.pos    = count_reg;
    assign push_entry.last   = text_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            window_reg <= window_next;
    end

endmodule

// ----- design/epm_fifo.sv -----
// Short queue between front and back ends.
// Depends on epm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epm_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  epm_pkg::epm_entry_t       push_entry,
    input  logic                      pop,
    output epm_pkg::epm_entry_t       head_entry,
    output epm_pkg::epm_fifo_status_t status
);
    import epm_pkg::*;

    localparam int PTR_BITS   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(FIFO_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(FIFO_DEPTH);

    epm_entry_t            entry_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    assign status.full  = (count_reg == COUNT_FULL);
    assign status.valid = (count_reg != '0);
    assign head_entry   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        if (push && !pop)
            count_next = count_reg + COUNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= COUNT_FULL, "fifo count overrun")
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !status.full || pop, "push into full fifo")
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, status.valid, "pop from empty fifo")
    `ASSERT_IMPLIES(a_ptr_gap, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg,
        "pointers differ while empty")

endmodule

// ----- design/epm_back.sv -----
// Back end: pattern registers, window compare and the output register.
// Depends on epm_pkg.
module epm_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [epm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [epm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  epm_pkg::epm_entry_t                  head_entry,
    input  epm_pkg::epm_fifo_status_t            fifo_status,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic [epm_pkg::START_BITS-1:0]       start_index,
    output logic                                 end_of_text
);
    import epm_pkg::*;

    logic [CFG_DATA_BITS-1:0] pat_low_reg;
    logic [CFG_DATA_BITS-1:0] pat_high_reg;
    logic [LEN_BITS-1:0]      pat_len_reg;
    pattern_t                 pattern;
    logic [LEN_BITS-1:0]      len_eff;
    logic [LEN_BITS-1:0]      len_m1;
    logic [MAX_PATTERN-1:0]   eq;
    logic [INDEX_BITS-1:0]    back_off;
    logic [INDEX_BITS-1:0]    start_pos;
    logic                     hit;

    logic                     valid_reg;
    logic                     found_reg;
    logic [START_BITS-1:0]    start_reg;
    logic                     last_reg;

    assign pattern = pattern_t'({pat_high_reg, pat_low_reg});
    assign len_eff = (pat_len_reg > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                             : pat_len_reg;
    assign len_m1  = len_eff - LEN_BITS'(1);

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            eq[j] = (LEN_BITS'(j) >= len_eff) ||
                    (head_entry.window[WIN_IDX_BITS'(len_m1 - LEN_BITS'(j))] == pattern[j]);
        end
    end

    assign back_off  = INDEX_BITS'(len_m1);
    assign start_pos = head_entry.pos - back_off;
    assign hit       = (len_eff != '0) && (head_entry.pos >= back_off) && (&eq);

    assign pop = fifo_status.valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg <= hit;
            start_reg <= hit ? START_BITS'(start_pos) : '0;
            last_reg  <= head_entry.last;
        end
    end

    assign out_valid   = valid_reg;
    assign found       = found_reg;
    assign start_index = start_reg;
    assign end_of_text = last_reg;

endmodule

// ----- tb/exact_pattern_matcher_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for exact_pattern_matcher: streams text beats, predicts
// each match result in step with the input and compares every output beat.
// Depends on epm_pkg and the exact_pattern_matcher RTL.
module exact_pattern_matcher_tb;
    import epm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct packed {
        logic                  found;
        logic [START_BITS-1:0] start_index;
        logic                  end_of_text;
    } match_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;   // text_byte
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [START_BITS-1:0]     m_tdata;   // start_index
    logic                      m_tuser;   // found
    logic                      m_tlast;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    exact_pattern_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's configuration and text state
    logic [63:0]                   cur_pat_low;
    logic [63:0]                   cur_pat_high;
    logic [LEN_BITS-1:0]           cur_pat_len;
    logic [WINDOW_DEPTH-1:0][7:0]  text_window;
    logic [INDEX_BITS-1:0]         text_pos;

    match_result_t expected_matches[$];
    logic [7:0]    text_buf[$];
    int            mismatch_count;
    int            cycle_count;
    int            hold_off_len;
    int            sink_stall;
    bit            src_idle_on;
    bit            sink_idle_on;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // advance the shadow by one text byte and return the match it produces
    function automatic match_result_t match_next(input logic [7:0] b, input logic l);
        match_result_t             res;
        logic [MAX_PATTERN-1:0][7:0] pat;
        int                        eff_len;
        int                        j;
        logic                      hit;
        pat = {cur_pat_high, cur_pat_low};
        text_window = {text_window[WINDOW_DEPTH-2:0], b};
        eff_len = (cur_pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_pat_len);
        hit = 1'b0;
        if (eff_len >= 1 && int'(text_pos) >= eff_len - 1)
        begin
            hit = 1'b1;
            for (j = 0; j < eff_len; j++)
                if (text_window[eff_len-1-j] != pat[j])
                    hit = 1'b0;
        end
        res.found       = hit;
        res.start_index = hit ? START_BITS'(text_pos - (eff_len - 1)) : '0;
        res.end_of_text = l;
        if (l)
            text_pos = '0;
        else if (text_pos != COUNT_MAX)
            text_pos = text_pos + 1'b1;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        match_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_matches.size() == 0)
                note_mismatch("unexpected beat, start_index", -1, m_tdata);
            else
            begin
                want = expected_matches.pop_front();
                if (m_tuser !== want.found)
                    note_mismatch("found", want.found, m_tuser);
                if (m_tdata !== want.start_index)
                    note_mismatch("start_index", want.start_index, m_tdata);
                if (m_tlast !== want.end_of_text)
                    note_mismatch("end_of_text", want.end_of_text, m_tlast);
            end
        end
    end

    // receiver: long hold-off on request, otherwise random stalls while sink_idle_on is set
    always @(posedge clk)
    begin : sink
        int g;
        if (hold_off_len > 0)
        begin
            m_tready <= 1'b0;
            hold_off_len <= hold_off_len - 1;
        end
        else if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (sink_idle_on)
        begin
            g = pick_gap();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                sink_stall <= g - 1;
            end
            else
                m_tready <= 1'b1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_matches = {expected_matches, match_next(b, l)};
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text_buf();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_beat(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len_word);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PATTERN_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cur_pat_low = lo;
        cfg_index <= CFG_PATTERN_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cur_pat_high = hi;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= len_word;
        @(posedge clk);
        cur_pat_len = len_word[LEN_BITS-1:0];
        cfg_we <= 1'b0;
    endtask

    // reset pattern, overlaps, pattern longer than text, zero length
    task automatic test_directed();
        text_buf = '{8'h00, 8'hFF, 8'h00};
        send_text_buf();
        set_config(64'h0000_0000_0000_6161, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
        text_buf = '{8'h61, 8'h61, 8'h61};
        send_text_buf();
        set_config(64'h0000_0000_007A_7978, 64'd0, 64'd3);
        text_buf = '{8'h78, 8'h79};
        send_text_buf();
        text_buf = '{8'h78, 8'h79, 8'h7A};
        send_text_buf();
        set_config(64'd0, 64'd0, 64'd0);
        text_buf = '{8'h00, 8'h00};
        send_text_buf();
    endtask

    // full sixteen-byte pattern, and an oversized length clamped to sixteen
    task automatic test_long_pattern();
        int i;
        set_config(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988, 64'd16);
        for (i = 0; i < MAX_PATTERN; i++)
            text_buf = {text_buf, 8'(i * 17)};
        send_text_buf();
        set_config(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988, 64'd31);
        text_buf = {text_buf, 8'hFF};
        for (i = 0; i < MAX_PATTERN; i++)
            text_buf = {text_buf, 8'(i * 17)};
        send_text_buf();
    endtask

    task automatic test_random_texts();
        logic [7:0]                  alpha[3];
        logic [MAX_PATTERN-1:0][7:0] pbytes;
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        logic [63:0]                 len_word;
        int                          phase;
        int                          sent;
        int                          tl;
        int                          r;
        int                          plen;
        int                          eff;
        int                          j;
        bit                          noisy;
        for (phase = 0; phase < 12; phase++)
        begin
            for (j = 0; j < 3; j++)
                alpha[j] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                alpha[1] = alpha[0];
            for (j = 0; j < MAX_PATTERN; j++)
                pbytes[j] = alpha[$urandom_range(0, 2)];
            lo = pbytes[7:0];
            hi = pbytes[15:8];
            if ($urandom_range(0, 4) == 0)
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                pbytes = {hi, lo};
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                plen = $urandom_range(1, 16);
            else if (r < 75)
                plen = 16;
            else if (r < 85)
                plen = 0;
            else
                plen = $urandom_range(17, 31);
            len_word = 64'(plen);
            if ($urandom_range(0, 2) == 0)
            begin
                len_word = {$urandom, $urandom};
                len_word[LEN_BITS-1:0] = LEN_BITS'(plen);
            end
            set_config(lo, hi, len_word);
            eff = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
            src_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on <= ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 80)
            begin
                tl = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 28);
                noisy = ($urandom_range(0, 9) == 0);
                while (text_buf.size() < tl)
                begin
                    if (!noisy && eff > 0 && $urandom_range(0, 3) == 0)
                    begin
                        for (j = 0; j < eff; j++)
                            text_buf = {text_buf, pbytes[j]};
                    end
                    else if (noisy || $urandom_range(0, 9) == 0)
                        text_buf = {text_buf, 8'($urandom_range(0, 255))};
                    else
                        text_buf = {text_buf, alpha[$urandom_range(0, 2)]};
                end
                sent += text_buf.size();
                send_text_buf();
            end
        end
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        int i;
        set_config(64'h0000_0000_0000_5A5A, 64'd0, 64'd2);
        src_idle_on = 1'b0;
        hold_off_len <= 60;
        for (i = 0; i < 30; i++)
            text_buf = {text_buf, (($urandom_range(0, 2) == 0) ? 8'h00 : 8'h5A)};
        send_text_buf();
        src_idle_on = 1'b1;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PATTERN_LOW;
        cfg_data       = '0;
        cur_pat_low    = '0;
        cur_pat_high   = '0;
        cur_pat_len    = LEN_BITS'(1);
        text_window    = '0;
        text_pos       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_off_len   = 0;
        sink_stall     = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_pattern();
        test_random_texts();
        test_backpressure();

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
